// File: design/posl_pkg.sv
// ----------------------------------------------------------------------------
// posl_pkg
// Shared types and codes for the positional array list.
// ----------------------------------------------------------------------------
`default_nettype none

package posl_pkg;

   localparam int DataWidth = 32;

   // command codes carried in the request
   typedef enum logic [2:0] {
      CMD_CLEAR  = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_DELETE = 3'd2,
      CMD_READ   = 3'd3,
      CMD_FIND   = 3'd4,
      CMD_SORTED = 3'd5
   } cmd_type;

   // response status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_RANGE   = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_MISSING = 2'd3;

   // operation broadcast to every cell
   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_CMP  = 2'd1,
      CELL_INS  = 2'd2,
      CELL_DEL  = 2'd3
   } cell_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      cell_op_type                 op;
      logic signed [DataWidth-1:0] value;
   } cell_ctrl_type;

   typedef struct packed {
      logic eq;   // holds the searched value, inside the list
      logic gt;   // greater than the searched value, inside the list
      logic sel;  // sits at the requested position
   } cell_flags_type;

endpackage

`default_nettype wire

// File: design/positional_array_list_top.sv
// ----------------------------------------------------------------------------
// positional_array_list_top
// Bounded ordered list kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, one element each, with the
// element count in a register. At the request transfer edge all cells
// compare their element against the request value and position and register
// the flags. In the next cycle a priority encoder picks the first match or
// insert point, the read/deleted element is selected, and on insert or
// delete the cells from the target position on shift by one cell in a
// single step. The response is registered at the end of that cycle and is
// offered from the cycle after. A new request can be taken in that same
// cycle if the response side takes the response; no request is taken while
// a command is in progress. While a response waits in the output register,
// a new request is taken only in the cycle the waiting response is
// transferred; a stalled response side stalls the input. Cells past the
// count hold stale data and are never reported. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_list_top
   import posl_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: [2:0] command, [10:3] position, [42:11] value, [47:43] zero
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [47:0] req_tdata,
   // response: [1:0] status, [33:2] element, [40:34] found_index,
   //           [48:41] count, [55:49] zero
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [55:0] rsp_tdata
);

   // count width, and a compare width that also covers the 8-bit position
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > 8) ? CW : 8;
   localparam logic [CW-1:0] Full = CW'(CAPACITY);

   // request fields
   logic [2:0]                  req_command;
   logic [7:0]                  req_position;
   logic signed [DataWidth-1:0] req_value;

   assign req_command  = req_tdata[2:0];
   assign req_position = req_tdata[10:3];
   assign req_value    = req_tdata[42:11];

   // control and latched request
   state_type                   state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [2:0]                  cmd_ff;
   logic [7:0]                  pos_ff;
   logic signed [DataWidth-1:0] val_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [55:0]                 rsp_data_ff, rsp_data_in;

   // cell row
   cell_ctrl_type               ctrl;
   logic [XW-1:0]               at;
   logic signed [DataWidth-1:0] elem_w [CAPACITY];
   cell_flags_type              flags_w [CAPACITY];
   logic [CAPACITY-1:0]         eq_vec, gt_vec, sel_vec;

   // result path
   logic                        req_transfer;
   logic [XW-1:0]               pos_x, cnt_x, eq_idx, gt_idx, ins_at;
   logic signed [DataWidth-1:0] sel_elem;
   logic [1:0]                  status;
   logic signed [DataWidth-1:0] element;
   logic [XW-1:0]               found_x, count_x;

   // lowest set bit of a flag vector, as an index
   function automatic logic [XW-1:0] first_set(input logic [CAPACITY-1:0] v);
      logic [CAPACITY-1:0] low;
      logic [XW-1:0]       idx;
      low = v & (~v + 1'b1);
      idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (low[i]) begin
            idx = idx | XW'(i);
         end
      end
      return idx;
   endfunction

   assign req_tready   = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_transfer = req_tvalid && req_tready;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         posl_cell #(
            .INDEX (g),
            .XW    (XW)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .at         (at),
            .count      (cnt_x),
            .left_elem  (elem_w[(g == 0) ? 0 : g - 1]),
            .right_elem (elem_w[(g == CAPACITY - 1) ? g : g + 1]),
            .elem       (elem_w[g]),
            .flags      (flags_w[g])
         );
         assign eq_vec[g]  = flags_w[g].eq;
         assign gt_vec[g]  = flags_w[g].gt;
         assign sel_vec[g] = flags_w[g].sel;
      end
   endgenerate

   // selection in ST_FINISH over the registered flags
   always_comb begin
      sel_elem = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         sel_elem = sel_elem | (elem_w[i] & {DataWidth{sel_vec[i]}});
      end
      eq_idx = first_set(eq_vec);
      gt_idx = (|gt_vec) ? first_set(gt_vec) : cnt_x;
   end

   always_comb begin
      pos_x        = XW'(pos_ff);
      cnt_x        = XW'(count_ff);
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ctrl.op      = CELL_HOLD;
      ctrl.value   = val_ff;
      at           = pos_x;
      status       = STATUS_OK;
      element      = '0;
      ins_at       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_transfer) begin
               // compare against the incoming request directly
               ctrl.op    = CELL_CMP;
               ctrl.value = req_value;
               at         = XW'(req_position);
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            unique case (cmd_ff)
               CMD_CLEAR: begin
                  count_in = '0;
               end
               CMD_INSERT: begin
                  if (pos_x > cnt_x) begin
                     status = STATUS_RANGE;
                  end else if (count_ff == Full) begin
                     status = STATUS_FULL;
                  end else begin
                     ctrl.op  = CELL_INS;
                     count_in = count_ff + 1'b1;
                  end
               end
               CMD_DELETE: begin
                  if (pos_x >= cnt_x) begin
                     status = STATUS_RANGE;
                  end else begin
                     element  = sel_elem;
                     ctrl.op  = CELL_DEL;
                     count_in = count_ff - 1'b1;
                  end
               end
               CMD_READ: begin
                  if (pos_x >= cnt_x) begin
                     status = STATUS_RANGE;
                  end else begin
                     element = sel_elem;
                  end
               end
               CMD_FIND: begin
                  if (|eq_vec) begin
                     ins_at = eq_idx;
                  end else begin
                     status = STATUS_MISSING;
                  end
               end
               CMD_SORTED: begin
                  if (count_ff == Full) begin
                     status = STATUS_FULL;
                  end else begin
                     ins_at   = gt_idx;
                     at       = gt_idx;
                     ctrl.op  = CELL_INS;
                     count_in = count_ff + 1'b1;
                  end
               end
               default: begin
                  // unused command codes: report only
               end
            endcase
            found_x      = ins_at;
            count_x      = XW'(count_in);
            rsp_data_in  = {7'd0, count_x[7:0], found_x[6:0], element, status};
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      found_x = ins_at;
      count_x = XW'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         cmd_ff <= req_command;
         pos_ff <= req_position;
         val_ff <= req_value;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Full)
      else $error("list count above capacity");

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> !req_tready)
      else $error("request taken while a command is in progress");

   a_rsp_follows: assert property (@(posedge clock)
      (req_tvalid && req_tready && !reset) ##1 !reset |=> rsp_tvalid)
      else $error("no response two cycles after a request transfer");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> (count_ff == $past(count_ff)))
      else $error("count changed outside command completion");

endmodule

`default_nettype wire

// File: design/posl_cell.sv
// ----------------------------------------------------------------------------
// posl_cell
// One list slot: holds an element, shifts with its neighbors, registers
// compare flags against the broadcast value and position.
// ----------------------------------------------------------------------------
`default_nettype none

module posl_cell
   import posl_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int XW    = 8
) (
   input  wire logic                        clock,
   input  wire cell_ctrl_type               ctrl,
   input  wire logic [XW-1:0]               at,
   input  wire logic [XW-1:0]               count,
   input  wire logic signed [DataWidth-1:0] left_elem,
   input  wire logic signed [DataWidth-1:0] right_elem,
   output      logic signed [DataWidth-1:0] elem,
   output      cell_flags_type              flags
);

   localparam logic [XW-1:0] MyIndex = XW'(INDEX);

   logic signed [DataWidth-1:0] elem_ff, elem_in;
   cell_flags_type              flags_ff, flags_in;
   logic                        inside_list;

   always_comb begin
      inside_list = MyIndex < count;
      elem_in     = elem_ff;
      flags_in    = flags_ff;
      case (ctrl.op)
         CELL_CMP: begin
            flags_in.eq  = inside_list && (elem_ff == ctrl.value);
            flags_in.gt  = inside_list && (ctrl.value < elem_ff);
            flags_in.sel = (MyIndex == at);
         end
         CELL_INS: begin
            if (MyIndex > at) begin
               elem_in = left_elem;
            end else if (MyIndex == at) begin
               elem_in = ctrl.value;
            end
         end
         CELL_DEL: begin
            if (MyIndex >= at) begin
               elem_in = right_elem;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      elem_ff  <= elem_in;
      flags_ff <= flags_in;
   end

   assign elem  = elem_ff;
   assign flags = flags_ff;

endmodule

`default_nettype wire
